// ===== hw/rtl/per_voice_rc_highpass_top_defines.svh =====
// Assertion macros shared by the high-pass filter checker.
`ifndef PER_VOICE_RC_HIGHPASS_TOP_DEFINES_SVH
`define PER_VOICE_RC_HIGHPASS_TOP_DEFINES_SVH

// Check a property once reset is released.
`define PVHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset cycles included.
`define PVHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pvhp_pkg.sv =====
// Types and constants for the per-voice RC high-pass filter.
package pvhp_pkg;

    localparam int VOICE_W    = 7;
    localparam int SAMPLE_W   = 16;
    localparam int CUTOFF_W   = 16;
    localparam int RATE_W     = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_VOICE_MODE = 1'd1;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
    localparam logic              MODE_RESET = 1'b1;

    // 2*pi in Q3.16
    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

    typedef logic [VOICE_W-1:0]         t_voice;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CUTOFF_W-1:0]        t_cutoff;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

endpackage

// ===== hw/rtl/pvhp_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module pvhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register read data; hold it between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/per_voice_rc_highpass_top.sv =====
// Per-voice first-order RC high-pass filter, top level.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | request   | i_in_valid / o_in_stall    | i_voice_index i_sample_in i_cutoff_hz
//  out     | result    | o_out_valid / i_out_stall  | o_voice_out o_sample_out o_clipped
//  cfg     | write     | i_cfg_we                   | i_cfg_index i_cfg_data
//
// A request runs from acceptance to the next acceptance through history read, three setup
// states, 17 restoring division steps for the coefficient, one multiply and one writeback.
// The coefficient divider yields one quotient bit per cycle.
// After reset a clearing pass writes zero history to all VOICES entries, one per cycle,
// with o_in_stall high; configuration writes are taken during it.
// A stalled result holds in the output register; the next request is accepted meanwhile
// and its writeback waits until the output register is free.
module per_voice_rc_highpass_top #(
    parameter int VOICES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pvhp_pkg::t_voice     i_voice_index,
    input  pvhp_pkg::t_sample    i_sample_in,
    input  pvhp_pkg::t_cutoff    i_cutoff_hz,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pvhp_pkg::t_voice     o_voice_out,
    output pvhp_pkg::t_sample    o_sample_out,
    output logic                 o_clipped,
    input  logic                 i_cfg_we,
    input  pvhp_pkg::t_cfg_idx   i_cfg_index,
    input  pvhp_pkg::t_cfg_data  i_cfg_data
);

    import pvhp_pkg::*;

    localparam int ADDR_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MOD_W  = VOICE_W + 11;
    localparam int S_W    = SAMPLE_W + 2;
    localparam int DEN_W  = 36;
    localparam int Q_W    = 17;
    localparam int CNT_W  = 5;
    localparam int P_W    = S_W + Q_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEN   = 3'd2;
    localparam logic [2:0] S_NUM   = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Reduce a voice number modulo VOICES by shifted compare and subtract
    function automatic t_voice wrap_voice(input t_voice v);
        logic [MOD_W-1:0] r;
        r = MOD_W'(v);
        for (int k = VOICE_W - 1; k >= 0; k--) begin
            if (r >= (MOD_W'(VOICES) << k)) begin
                r = r - (MOD_W'(VOICES) << k);
            end
        end
        return r[VOICE_W-1:0];
    endfunction

    logic [2:0]              r_state, n_state;
    logic [ADDR_W-1:0]       r_clr;
    logic [RATE_W-1:0]       r_rate;
    logic                    r_mode;

    t_voice                  r_voice;
    logic [ADDR_W-1:0]       r_addr;
    t_sample                 r_x;
    t_cutoff                 r_fc;
    logic [34:0]             r_prod;
    logic signed [S_W-1:0]   r_s;
    logic [DEN_W-1:0]        r_den;
    logic                    r_den_zero;
    logic [DEN_W:0]          r_rem;
    logic [Q_W-1:0]          r_lo;
    logic [Q_W-1:0]          r_q;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [P_W-1:0]   r_p;

    logic                    r_out_valid;
    t_voice                  r_voice_out;
    t_sample                 r_sample_out;
    logic                    r_clipped;

    logic                    in_take;
    logic                    out_free;
    logic                    wb_go;
    t_voice                  eff_voice;
    logic [2*SAMPLE_W-1:0]   rd_data;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [2*SAMPLE_W-1:0]   ram_wdata;
    logic [50:0]             num;
    logic [DEN_W:0]          trial;
    logic [DEN_W:0]          trial_sub;
    logic [SAMPLE_W-1:0]     alpha;
    logic signed [P_W:0]     p_round;
    logic signed [19:0]      y_wide;
    t_sample                 y_sat;
    logic                    y_clip;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_RATE:    r_rate <= i_cfg_data[RATE_W-1:0];
                CFG_PER_VOICE_MODE: r_mode <= i_cfg_data[0];
            endcase
        end
    end

    assign in_take   = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign wb_go     = (r_state == S_DONE) && out_free;
    assign eff_voice = r_mode ? wrap_voice(i_voice_index) : '0;

    // History memory: {prev_output, prev_input} per voice
    assign ram_we    = (r_state == S_CLEAR) || wb_go;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : {y_sat, r_x};

    pvhp_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (VOICES),
        .AW    (ADDR_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_take),
        .i_raddr (ADDR_W'(eff_voice)),
        .o_rdata (rd_data)
    );

    // Numerator fs*2^32 + D/2 and one restoring division step
    assign num       = {1'b0, r_rate, 32'd0} + 51'(r_den >> 1);
    assign trial     = {r_rem[DEN_W-1:0], r_lo[Q_W-1]};
    assign trial_sub = trial - {1'b0, r_den};

    // Clamp the quotient to Q0.16; zero denominator gives zero
    always_comb begin
        if (r_den_zero) begin
            alpha = '0;
        end else if (r_q[Q_W-1]) begin
            alpha = '1;
        end else begin
            alpha = r_q[SAMPLE_W-1:0];
        end
    end

    // Round half up and saturate to Q1.15
    assign p_round = (P_W + 1)'(r_p) + (P_W + 1)'(32768);
    assign y_wide  = p_round[35:16];

    always_comb begin
        y_clip = 1'b0;
        y_sat  = y_wide[SAMPLE_W-1:0];
        if (y_wide > 20'sd32767) begin
            y_sat  = 16'sh7FFF;
            y_clip = 1'b1;
        end else if (y_wide < -20'sd32768) begin
            y_sat  = 16'sh8000;
            y_clip = 1'b1;
        end
    end

    // Sequence one request through read, divide, multiply and writeback
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == ADDR_W'(VOICES - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_take) n_state = S_DEN;
            S_DEN:   n_state = S_NUM;
            S_NUM:   n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(Q_W - 1)) n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_voice <= eff_voice;
            r_addr  <= ADDR_W'(eff_voice);
            r_x     <= i_sample_in;
            r_fc    <= i_cutoff_hz;
        end
        if (r_state == S_DEN) begin
            r_prod <= 35'(r_fc) * 35'(TWO_PI_Q16);
            r_s    <= S_W'($signed(rd_data[2*SAMPLE_W-1:SAMPLE_W]))
                    + S_W'(r_x)
                    - S_W'($signed(rd_data[SAMPLE_W-1:0]));
        end
        if (r_state == S_NUM) begin
            r_den <= {2'b00, r_rate, 16'd0} + DEN_W'(r_prod);
        end
        if (r_state == S_PREP) begin
            r_rem      <= (DEN_W + 1)'(num[50:Q_W]);
            r_lo       <= num[Q_W-1:0];
            r_cnt      <= '0;
            r_den_zero <= (r_den == '0);
        end
        if (r_state == S_DIV) begin
            if (!trial_sub[DEN_W]) begin
                r_rem <= trial_sub;
            end else begin
                r_rem <= trial;
            end
            r_q   <= {r_q[Q_W-2:0], !trial_sub[DEN_W]};
            r_lo  <= {r_lo[Q_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_state == S_MUL) begin
            r_p <= P_W'($signed({1'b0, alpha})) * P_W'(r_s);
        end
    end

    // Output register: load on writeback, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            r_voice_out  <= r_voice;
            r_sample_out <= y_sat;
            r_clipped    <= y_clip;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_voice_out  = r_voice_out;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

// ===== hw/rtl/pvhp_checker.sv =====
// Port-level assertions for the per-voice RC high-pass filter, with bind.
`include "per_voice_rc_highpass_top_defines.svh"

module pvhp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input pvhp_pkg::t_voice     i_voice_index,
    input pvhp_pkg::t_sample    i_sample_in,
    input pvhp_pkg::t_cutoff    i_cutoff_hz,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input pvhp_pkg::t_voice     o_voice_out,
    input pvhp_pkg::t_sample    o_sample_out,
    input logic                 o_clipped,
    input logic                 i_cfg_we,
    input pvhp_pkg::t_cfg_idx   i_cfg_index,
    input pvhp_pkg::t_cfg_data  i_cfg_data
);

    import pvhp_pkg::*;

    // No result is offered right after reset
    `PVHP_ASSERT_ALWAYS(a_out_idle_after_reset, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // One request at a time: stall right after an accept
    `PVHP_ASSERT(a_one_in_flight, (i_in_valid && !o_in_stall) |=> o_in_stall, "second request taken")

    // A clipped result sits at a rail
    `PVHP_ASSERT(a_clip_at_rail, (o_out_valid && o_clipped) |-> (o_sample_out == 16'sh7FFF || o_sample_out == 16'sh8000), "clipped result off the rails")

    // A stalled result holds
    `PVHP_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out) && $stable(o_voice_out) && $stable(o_clipped)), "stalled result changed")

endmodule

bind per_voice_rc_highpass_top pvhp_checker u_pvhp_checker (.*);
